>>> rtl/sbn_pkg.sv
// package for the point cloud to scan binner
// shared constants, register and command codes, and the cordic arctangent table
package sbn_pkg;

    localparam int NUM_BINS_DEF     = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int LEN_W = 20;   // millimetre fields
    localparam int ANG_W = 16;   // q13 angles
    localparam int CX_W  = 27;   // cordic x and y datapath
    localparam int CZ_W  = 21;   // cordic angle, q16
    localparam int BR_W  = 18;   // bearing out of the cordic, q13
    localparam int DV_W  = 18;   // divider dividend and quotient
    localparam int USED_W = 11;

    localparam logic signed [CZ_W-1:0] PI_Q16   = 21'sd205887;
    localparam logic [23:0]            GAIN_Q24 = 24'd10188014;

    // command codes
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_HEIGHT_LOW   = 3'd0;
    localparam logic [2:0] REG_HEIGHT_HIGH  = 3'd1;
    localparam logic [2:0] REG_DIST_LOW     = 3'd2;
    localparam logic [2:0] REG_DIST_HIGH    = 3'd3;
    localparam logic [2:0] REG_BEARING_LOW  = 3'd4;
    localparam logic [2:0] REG_BEARING_HIGH = 3'd5;
    localparam logic [2:0] REG_BEARING_STEP = 3'd6;
    localparam logic [2:0] REG_EMPTY_FILL   = 3'd7;

    function automatic logic signed [CZ_W-1:0] atan_q16(input int i);
        logic signed [CZ_W-1:0] v;
        case (i)
            0:  v = 21'sd51472;
            1:  v = 21'sd30386;
            2:  v = 21'sd16055;
            3:  v = 21'sd8150;
            4:  v = 21'sd4091;
            5:  v = 21'sd2047;
            6:  v = 21'sd1024;
            7:  v = 21'sd512;
            8:  v = 21'sd256;
            9:  v = 21'sd128;
            10: v = 21'sd64;
            11: v = 21'sd32;
            12: v = 21'sd16;
            13: v = 21'sd8;
            14: v = 21'sd4;
            15: v = 21'sd2;
            16: v = 21'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/point_cloud_to_scan_binner.sv
// top level of the point cloud to scan binner: sequencer, registers, bin ram
// depends on sbn_pkg, sbn_ram, sbn_cordic and sbn_div
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_kind, i_x_mm, i_y_mm, i_z_mm,
//           |           |                           | i_point_bad, i_read_bin
//  out      | out       | o_out_valid / i_out_stall | o_bin_range, o_bin_number, o_bins_used
//  cfg      | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// a point that reaches its bin goes through the cordic pass, the divider, a ram read and
// the update; height-rejected points are dropped without a cordic pass.
// a read goes through a ram read state and an output state, waiting for the output register.
// a start clears the bins with a pass over all NUM_BINS ram entries, then divides for the bin
// count when the bearing span is positive; the same clearing pass runs after reset, with the input stalled.
module point_cloud_to_scan_binner
    import sbn_pkg::*;
#(
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_kind,
    input  logic signed [LEN_W-1:0] i_x_mm,
    input  logic signed [LEN_W-1:0] i_y_mm,
    input  logic signed [LEN_W-1:0] i_z_mm,
    input  logic                    i_point_bad,
    input  logic [9:0]              i_read_bin,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LEN_W-1:0]        o_bin_range,
    output logic [9:0]              o_bin_number,
    output logic [USED_W-1:0]       o_bins_used,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [LEN_W-1:0]        i_cfg_data
);
    localparam int AW = $clog2(NUM_BINS);
    localparam int TW = $clog2(NUM_BINS + 1);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PT_COR = 4'd2;
    localparam logic [3:0] S_PT_DIV = 4'd3;
    localparam logic [3:0] S_PT_RD  = 4'd4;
    localparam logic [3:0] S_PT_UPD = 4'd5;
    localparam logic [3:0] S_ST_DIV = 4'd6;
    localparam logic [3:0] S_RD_RAM = 4'd7;
    localparam logic [3:0] S_RD_OUT = 4'd8;

    // configuration
    logic signed [LEN_W-1:0] r_height_low, r_height_high;
    logic [LEN_W-1:0]        r_dist_low, r_dist_high, r_empty_fill;
    logic signed [ANG_W-1:0] r_bearing_low, r_bearing_high;
    logic [ANG_W-1:0]        r_bearing_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_low   <= -20'sd524288;
            r_height_high  <= 20'sd524287;
            r_dist_low     <= 20'd0;
            r_dist_high    <= 20'd1048574;
            r_bearing_low  <= -16'sd25736;
            r_bearing_high <= 16'sd25736;
            r_bearing_step <= 16'd143;
            r_empty_fill   <= 20'd1048575;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HEIGHT_LOW:   r_height_low   <= i_cfg_data;
                REG_HEIGHT_HIGH:  r_height_high  <= i_cfg_data;
                REG_DIST_LOW:     r_dist_low     <= i_cfg_data;
                REG_DIST_HIGH:    r_dist_high    <= i_cfg_data;
                REG_BEARING_LOW:  r_bearing_low  <= i_cfg_data[ANG_W-1:0];
                REG_BEARING_HIGH: r_bearing_high <= i_cfg_data[ANG_W-1:0];
                REG_BEARING_STEP: r_bearing_step <= i_cfg_data[ANG_W-1:0];
                REG_EMPTY_FILL:   r_empty_fill   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [3:0]        r_state;
    logic              r_after_start;
    logic [AW-1:0]     r_clr_idx;
    logic [AW-1:0]     r_idx;
    logic [9:0]        r_rd_bin;
    logic              r_rd_in_range;
    logic [TW-1:0]     r_total;
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_range;
    logic [9:0]        r_out_bin;
    logic [USED_W-1:0] r_out_used;

    logic in_accept;
    logic [ANG_W-1:0] step_eff;
    logic signed [ANG_W:0] span;
    logic [DV_W-1:0] span_dvd, pt_dvd;
    logic signed [BR_W:0] rel;

    logic cor_done;
    logic [LEN_W-1:0] cor_range;
    logic signed [BR_W-1:0] cor_bearing;
    logic div_start, div_done;
    logic [DV_W-1:0] div_dvd, div_q;
    logic pt_pass, pt_keep;
    logic [31:0] q_ext, rd_ext, tot_ext;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [LEN_W:0] ram_wdata, ram_rdata;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        step_eff = (r_bearing_step == '0) ? 16'd1 : r_bearing_step;
        span     = (ANG_W+1)'(r_bearing_high) - (ANG_W+1)'(r_bearing_low);
        span_dvd = DV_W'(span[ANG_W-1:0]) + DV_W'(step_eff) - 18'd1;
        rel      = (BR_W+1)'(cor_bearing) - (BR_W+1)'(r_bearing_low);
        pt_dvd   = rel[DV_W-1:0];
        pt_pass  = !(cor_range < r_dist_low) && !(cor_range > r_dist_high)
                && !(cor_bearing < BR_W'(r_bearing_low))
                && !(cor_bearing > BR_W'(r_bearing_high));
        div_start = ((r_state == S_PT_COR) && cor_done && pt_pass)
                 || ((r_state == S_CLR) && (r_clr_idx == AW'(NUM_BINS - 1))
                     && r_after_start && (span > 0));
        div_dvd  = (r_state == S_PT_COR) ? pt_dvd : span_dvd;
        q_ext    = 32'(div_q);
        tot_ext  = 32'(r_total);
        rd_ext   = 32'(i_read_bin);
        // the first hit in a bin always stores its range; later hits keep the nearer one
        pt_keep  = !ram_rdata[LEN_W] || (cor_range < ram_rdata[LEN_W-1:0]);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = {1'b1, cor_range};
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_idx;
            ram_wdata = '0;
        end else if (r_state == S_PT_UPD) begin
            ram_we = pt_keep;
        end
    end

    sbn_ram #(.WIDTH(LEN_W + 1), .DEPTH(NUM_BINS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sbn_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_accept && (i_kind == KIND_POINT) && !i_point_bad
                    && !(i_z_mm > r_height_high) && !(i_z_mm < r_height_low)),
        .i_x       (i_x_mm),
        .i_y       (i_y_mm),
        .o_done    (cor_done),
        .o_range   (cor_range),
        .o_bearing (cor_bearing)
    );

    sbn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (step_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_after_start <= 1'b0;
            r_clr_idx     <= '0;
            r_total       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // the read state loads or holds the output register itself
            if (!i_out_stall && (r_state != S_RD_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_clr_idx == AW'(NUM_BINS - 1)) begin
                        r_clr_idx <= '0;
                        if (!r_after_start) begin
                            r_state <= S_IDLE;
                        end else if (span > 0) begin
                            r_state <= S_ST_DIV;
                        end else begin
                            r_total <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_kind)
                            KIND_POINT: begin
                                if (!i_point_bad && !(i_z_mm > r_height_high)
                                        && !(i_z_mm < r_height_low)) begin
                                    r_state <= S_PT_COR;
                                end
                            end
                            KIND_START: begin
                                r_after_start <= 1'b1;
                                r_state       <= S_CLR;
                            end
                            KIND_READ: begin
                                r_idx         <= rd_ext[AW-1:0];
                                r_rd_bin      <= i_read_bin;
                                r_rd_in_range <= rd_ext < 32'(NUM_BINS);
                                r_state       <= S_RD_RAM;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PT_COR: begin
                    if (cor_done) begin
                        r_state <= pt_pass ? S_PT_DIV : S_IDLE;
                    end
                end
                S_PT_DIV: begin
                    if (div_done) begin
                        r_idx   <= div_q[AW-1:0];
                        r_state <= (q_ext >= tot_ext) ? S_IDLE : S_PT_RD;
                    end
                end
                S_PT_RD:  r_state <= S_PT_UPD;
                S_PT_UPD: r_state <= S_IDLE;
                S_ST_DIV: begin
                    if (div_done) begin
                        r_total <= (q_ext > 32'(NUM_BINS)) ? TW'(NUM_BINS) : div_q[TW-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_RD_RAM: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_range <= (r_rd_in_range && ram_rdata[LEN_W])
                                     ? ram_rdata[LEN_W-1:0] : r_empty_fill;
                        r_out_bin   <= r_rd_bin;
                        r_out_used  <= tot_ext[USED_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_range  = r_out_range;
    assign o_bin_number = r_out_bin;
    assign o_bins_used  = r_out_used;

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_RD_OUT)
        else $error("result item without a read");

    a_ram_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR) || (r_state == S_PT_UPD))
        else $error("bin ram written outside clear or update");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tot_ext <= 32'(NUM_BINS))
        else $error("bin count above bin capacity");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_bin_range)
            && $stable(o_bins_used))
        else $error("stalled result item lost");
endmodule

>>> rtl/sbn_ram.sv
// generic single port ram with registered read
// no dependencies
module sbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sbn_cordic.sv
// iterative cordic vectoring unit: planar range and bearing of one point
// depends on sbn_pkg for widths, pi, gain and the arctangent table
module sbn_cordic
    import sbn_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [LEN_W-1:0] i_x,
    input  logic signed [LEN_W-1:0] i_y,
    output logic                    o_done,
    output logic [LEN_W-1:0]        o_range,
    output logic signed [BR_W-1:0]  o_bearing
);
    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_MUL  = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]             r_state;
    logic [CW-1:0]          r_i;
    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;
    logic                   r_zero;
    logic [49:0]            r_prod;
    logic                   r_done;
    logic [LEN_W-1:0]       r_range;
    logic signed [BR_W-1:0] r_bearing;

    logic signed [CX_W-1:0] xe, ye, xs, ys;
    logic [CX_W-2:0]        xc;
    logic [49:0]            rsum;
    logic [21:0]            rq;
    logic signed [CZ_W-1:0] zr;

    always_comb begin
        xe   = CX_W'(i_x) <<< 4;
        ye   = CX_W'(i_y) <<< 4;
        xs   = r_x >>> r_i;
        ys   = r_y >>> r_i;
        xc   = r_x[CX_W-1] ? '0 : r_x[CX_W-2:0];
        rsum = r_prod + 50'd134217728;
        rq   = rsum[49:28];
        zr   = (r_z + 21'sd4) >>> 3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_RUN;
                        r_i     <= '0;
                        r_zero  <= (i_x == '0) && (i_y == '0);
                        // left half plane: turn by pi first
                        if (i_x < 0) begin
                            r_x <= -xe;
                            r_y <= -ye;
                            r_z <= (i_y >= 0) ? PI_Q16 : -PI_Q16;
                        end else begin
                            r_x <= xe;
                            r_y <= ye;
                            r_z <= '0;
                        end
                    end
                end
                C_RUN: begin
                    if (!r_y[CX_W-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_q16(int'(r_i));
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_q16(int'(r_i));
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CW'(CORDIC_STEPS - 1)) begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_prod  <= 50'(xc) * 50'(GAIN_Q24);
                    r_state <= C_FIN;
                end
                C_FIN: begin
                    if (r_zero) begin
                        r_range   <= '0;
                        r_bearing <= '0;
                    end else begin
                        r_range   <= (rq > 22'h0FFFFF) ? 20'hFFFFF : rq[LEN_W-1:0];
                        r_bearing <= zr[BR_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_range   = r_range;
    assign o_bearing = r_bearing;
endmodule

>>> rtl/sbn_div.sv
// restoring divider, one quotient bit per cycle
// depends on sbn_pkg for widths
module sbn_div
    import sbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DV_W-1:0]   i_dividend,
    input  logic [ANG_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DV_W-1:0]   o_quotient
);
    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DV_W-1:0]   r_q;
    logic [ANG_W-1:0]  r_rem;
    logic [ANG_W-1:0]  r_d;

    logic [ANG_W:0] trial, diff;
    logic           fits;

    always_comb begin
        trial = {r_rem, r_q[DV_W-1]};
        diff  = trial - {1'b0, r_d};
        fits  = trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_q    <= i_dividend;
                    r_rem  <= '0;
                    r_d    <= i_divisor;
                end
            end else begin
                r_rem <= fits ? diff[ANG_W-1:0] : trial[ANG_W-1:0];
                r_q   <= {r_q[DV_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(DV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
